FILE: src/bato_pkg.sv
package bato_pkg;

	// default sizes of the list
	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	// fixed field widths on the ports
	localparam int OP_W  = 3;
	localparam int IDX_W = 5;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	// packed stream widths, padded to whole bytes
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 48;
	localparam int S_PAD    = S_DATA_W - IDX_W - VAL_W;
	localparam int M_PAD    = M_DATA_W - VAL_W - 2 * IDX_W;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_SEARCH = 3'd3,
		OP_GET    = 3'd4,
		OP_SORTED = 3'd5
	} op_t;

	// per-cycle update commands broadcast along the cell row
	typedef struct packed {
		logic app;
		logic ins;
		logic del;
		logic srch;
		logic srt;
	} ctl_t;

endpackage

FILE: src/bato_cell.sv
module bato_cell #(
	parameter int I  = 0,
	parameter int CW = 5,
	parameter int WB = 32
) (
	input  logic          clk,
	input  logic [CW-1:0] cnt,
	input  logic [CW-1:0] tgt,
	input  logic [WB-1:0] val,
	input  bato_pkg::ctl_t ctl,
	input  logic [WB-1:0] left_word,
	input  logic [WB-1:0] right_word,
	input  logic          seen_in,
	input  logic          allg_in,
	input  logic          allg_left,
	input  logic          first_right,
	output logic [WB-1:0] slot,
	output logic          seen_out,
	output logic          first,
	output logic          allg_out,
	output logic          pos
);

	localparam logic [CW-1:0] ME  = CW'(I);
	localparam logic [CW-1:0] ME1 = CW'(I + 1);

	logic [WB-1:0] slot_q;
	logic          in_use;
	logic          below_top;
	logic          eq;
	logic          gt;

	// position against the fill count
	assign in_use    = ME < cnt;
	assign below_top = ME <= cnt;

	// search match, first one from the front
	assign eq       = in_use && (slot_q == val);
	assign seen_out = seen_in | eq;
	assign first    = eq & ~seen_in;

	// sorted insert: this slot and all used ones above it are greater
	assign gt       = $signed(slot_q) > $signed(val);
	assign allg_out = allg_in & (~in_use | gt);
	assign pos      = below_top & allg_out & ~allg_left;

	assign slot = slot_q;

	// slot update from the input value, left or right neighbour
	always_ff @(posedge clk) begin
		if (ctl.app && ME == cnt) begin
			slot_q <= val;
		end else if (ctl.ins && ME == tgt) begin
			slot_q <= val;
		end else if (ctl.ins && ME > tgt && below_top) begin
			slot_q <= left_word;
		end else if (ctl.del && ME >= tgt && ME1 < cnt) begin
			slot_q <= right_word;
		end else if (ctl.srch && first && ME != '0) begin
			slot_q <= left_word;
		end else if (ctl.srch && first_right) begin
			slot_q <= right_word;
		end else if (ctl.srt && pos) begin
			slot_q <= val;
		end else if (ctl.srt && below_top && allg_left) begin
			slot_q <= left_word;
		end
	end

endmodule

FILE: src/bato_chain.sv
module bato_chain #(
	parameter int DEPTH = 16,
	parameter int WB    = 32,
	parameter int CW    = 5,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic [CW-1:0] cnt,
	input  logic [CW-1:0] tgt,
	input  logic [WB-1:0] val,
	input  bato_pkg::ctl_t ctl,
	output logic [WB-1:0] rd_word,
	output logic          found,
	output logic [CW-1:0] hit_idx,
	output logic [CW-1:0] pos_idx
);

	logic [WB-1:0]    slot_w [DEPTH];
	logic [DEPTH:0]   seen_w;
	logic [DEPTH:0]   ag_w;
	logic [DEPTH-1:0] first_w;
	logic [DEPTH-1:0] pos_w;

	// chain ends
	assign seen_w[0]     = 1'b0;
	assign ag_w[DEPTH]   = 1'b1;
	assign found         = seen_w[DEPTH];

	// row of slot cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WB-1:0] lw;
		logic [WB-1:0] rw;
		logic          al;
		logic          fr;

		if (i == 0) begin : g_lo
			assign lw = '0;
			assign al = 1'b0;
		end else begin : g_mid_lo
			assign lw = slot_w[i-1];
			assign al = ag_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_hi
			assign rw = '0;
			assign fr = 1'b0;
		end else begin : g_mid_hi
			assign rw = slot_w[i+1];
			assign fr = first_w[i+1];
		end

		bato_cell #(
			.I  (i),
			.CW (CW),
			.WB (WB)
		) u_cell (
			.clk         (clk),
			.cnt         (cnt),
			.tgt         (tgt),
			.val         (val),
			.ctl         (ctl),
			.left_word   (lw),
			.right_word  (rw),
			.seen_in     (seen_w[i]),
			.allg_in     (ag_w[i+1]),
			.allg_left   (al),
			.first_right (fr),
			.slot        (slot_w[i]),
			.seen_out    (seen_w[i+1]),
			.first       (first_w[i]),
			.allg_out    (ag_w[i]),
			.pos         (pos_w[i])
		);
	end

	// read port for get and delete
	assign rd_word = slot_w[tgt[AW-1:0]];

	// one-hot to slot number for search hit and sorted position
	always_comb begin
		hit_idx = '0;
		pos_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_w[i]) begin
				hit_idx = hit_idx | CW'(i);
			end
			if (pos_w[i]) begin
				pos_idx = pos_idx | CW'(i);
			end
		end
	end

endmodule

FILE: src/bounded_array_table_ops_top.sv
// path: an accepted item is held in the input stage, its result in the result register on the master side
// throughput: one item per cycle while m_tready does not stall the output, set by the
//   row of slot cells, which compare, shift and update every slot as the item commits
// reset: arst_n clears the fill count and the handshake state and sets capacity to 16;
//   slot contents stay undefined until written, with no clearing pass
module bounded_array_table_ops_top #(
	parameter int DEPTH     = bato_pkg::DEPTH_DEF,
	parameter int WORD_BITS = bato_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bato_pkg::S_DATA_W-1:0] s_tdata,   // index, value
	input  logic [bato_pkg::OP_W-1:0]     s_tuser,   // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bato_pkg::M_DATA_W-1:0] m_tdata,   // value_out, index_out, count_out
	output logic                          m_tuser,   // ok
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bato_pkg::CAP_W-1:0]    cfg_data   // capacity
);

	import bato_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	logic [CAP_W-1:0]     cap_q;
	logic [CW-1:0]        count_q;
	logic                 s1_valid_q;
	logic                 out_valid_q;
	logic [OP_W-1:0]      op_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [VAL_W-1:0]     val_s1;
	logic [VAL_W-1:0]     vout_q;
	logic [IDX_W-1:0]     iout_q;
	logic                 ok_q;
	logic [IDX_W-1:0]     cnt_out_q;

	logic                 adv;
	logic                 commit;
	logic [WORD_BITS-1:0] val_w;
	logic [XW-1:0]        idx_x;
	logic [XW-1:0]        cnt_x;
	logic                 room;
	logic                 idx_le;
	logic                 idx_lt;
	logic [CW-1:0]        tgt;
	ctl_t                 ctl;
	logic                 ok_d;
	logic [CW-1:0]        iout_d;
	logic [VAL_W-1:0]     vout_d;
	logic [CW-1:0]        cnt_d;
	logic [WORD_BITS-1:0] rd_word;
	logic                 found;
	logic [CW-1:0]        hit_idx;
	logic [CW-1:0]        pos_idx;

	// handshake
	assign adv       = ~out_valid_q | m_tready;
	assign s_tready  = ~s1_valid_q | adv;
	assign commit    = s1_valid_q & adv;
	assign cfg_ready = 1'b1;

	// operand preparation and range checks
	assign val_w  = WORD_BITS'($signed(val_s1));
	assign idx_x  = XW'(idx_s1);
	assign cnt_x  = XW'(count_q);
	assign room   = (cnt_x < XW'(cap_q)) && (count_q < CW'(DEPTH));
	assign idx_le = idx_x <= cnt_x;
	assign idx_lt = idx_x < cnt_x;
	assign tgt    = CW'(idx_s1);

	// operation decode
	always_comb begin
		ctl    = '0;
		ok_d   = 1'b0;
		iout_d = '0;
		vout_d = '0;
		cnt_d  = count_q;
		unique case (op_s1)
			OP_APPEND: begin
				if (room) begin
					ctl.app = commit;
					ok_d    = 1'b1;
					iout_d  = count_q;
					cnt_d   = count_q + CW'(1);
				end
			end
			OP_INSERT: begin
				if (room && idx_le) begin
					ctl.ins = commit;
					ok_d    = 1'b1;
					iout_d  = tgt;
					cnt_d   = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (idx_lt) begin
					ctl.del = commit;
					ok_d    = 1'b1;
					vout_d  = VAL_W'(rd_word);
					cnt_d   = count_q - CW'(1);
				end
			end
			OP_SEARCH: begin
				if (found) begin
					ctl.srch = commit;
					ok_d     = 1'b1;
					iout_d   = hit_idx;
				end
			end
			OP_GET: begin
				if (idx_lt) begin
					ok_d   = 1'b1;
					vout_d = VAL_W'(rd_word);
				end
			end
			OP_SORTED: begin
				if (room) begin
					ctl.srt = commit;
					ok_d    = 1'b1;
					iout_d  = pos_idx;
					cnt_d   = count_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// slot cells
	bato_chain #(
		.DEPTH (DEPTH),
		.WB    (WORD_BITS),
		.CW    (CW),
		.AW    (AW)
	) u_chain (
		.clk     (clk),
		.cnt     (count_q),
		.tgt     (tgt),
		.val     (val_w),
		.ctl     (ctl),
		.rd_word (rd_word),
		.found   (found),
		.hit_idx (hit_idx),
		.pos_idx (pos_idx)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (commit) begin
				count_q <= cnt_d;
			end
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// input stage and result register
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			idx_s1 <= s_tdata[IDX_W-1:0];
			val_s1 <= s_tdata[IDX_W +: VAL_W];
		end
		if (commit) begin
			vout_q    <= vout_d;
			iout_q    <= IDX_W'(iout_d);
			ok_q      <= ok_d;
			cnt_out_q <= IDX_W'(cnt_d);
		end
	end

	// result packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD{1'b0}}, cnt_out_q, iout_q, vout_q};
	assign m_tuser  = ok_q;

endmodule

FILE: src/bato_checker.sv
module bato_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bato_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	import bato_pkg::*;

	// input side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a held result");

	// failed item reports slot zero
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[VAL_W +: IDX_W] == '0))
		else $error("failed item with nonzero index");

	// failed item returns no word
	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[VAL_W-1:0] == '0))
		else $error("failed item with nonzero value");

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

endmodule

bind bounded_array_table_ops_top bato_checker u_bato_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
